@@ rtl/scmp_pkg.sv @@
// ----------------------------------------------------------------------------
// scmp_pkg
// Shared types, codes and constants of the size class mapping predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package scmp_pkg;

    localparam int unsigned DEF_MAX_SIZE_CLASS = 1023;
    localparam int unsigned DEF_INTERVAL_CAP   = 1024;
    localparam int unsigned DEF_DECAY_SUM      = 64;

    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned OBS_W   = 2;
    localparam int unsigned LFSR_W  = 32;
    localparam int unsigned RATIO   = 10;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'h0000_0001;

    localparam logic [OBS_W-1:0] OBS_OPEN     = 2'd0;
    localparam logic [OBS_W-1:0] OBS_RESTRICT = 2'd1;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_RECORD = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic clear_wr;
        logic exec_wr;
        logic div_start;
        logic div_step;
        logic fin_wr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic need_div;
        logic div_last;
        logic clear_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic quick_hit;
        logic pred_type;
        logic out_of_range;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/scmp_if.sv @@
// ----------------------------------------------------------------------------
// scmp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface scmp_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] size_class;
    logic [1:0]  observed_mapping;

    modport source (output valid, output op, output size_class,
                    output observed_mapping, input ready);
    modport sink   (input valid, input op, input size_class,
                    input observed_mapping, output ready);
endinterface

interface scmp_out_if;
    logic valid;
    logic ready;
    logic quick_hit;
    logic pred_type;
    logic out_of_range;

    modport source (output valid, output quick_hit, output pred_type,
                    output out_of_range, input ready);
    modport sink   (input valid, input quick_hit, input pred_type,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

@@ rtl/scmp_ctrl.sv @@
// ----------------------------------------------------------------------------
// scmp_ctrl
// Sequencer: table clear after reset, read-modify-write and backoff steps.
// ----------------------------------------------------------------------------
`default_nettype none

module scmp_ctrl import scmp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_stat.in_range ? S_EXEC : S_DONE;
                end
            end
            S_EXEC: begin
                if (i_stat.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.exec_wr = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin_wr = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/scmp_dp.sv @@
// ----------------------------------------------------------------------------
// scmp_dp
// Datapath: entry memory, count update and classify, lfsr, serial remainder
// unit for the interval backoff, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scmp_dp import scmp_pkg::*; #(
    parameter int unsigned MAX_SIZE_CLASS = DEF_MAX_SIZE_CLASS,
    parameter int unsigned INTERVAL_CAP   = DEF_INTERVAL_CAP,
    parameter int unsigned DECAY_SUM      = DEF_DECAY_SUM
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_stat               o_stat,
    input  wire logic              i_cfg_we,
    input  wire logic [LFSR_W-1:0] i_cfg_wdata,
    input  wire logic              i_op,
    input  wire logic [SIZE_W-1:0] i_size_class,
    input  wire logic [OBS_W-1:0]  i_observed_mapping,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_quick_hit,
    output logic                   o_pred_type,
    output logic                   o_out_of_range
);

    localparam int unsigned DEPTH = MAX_SIZE_CLASS + 1;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DECAY_SUM + 1);
    localparam int unsigned IW    = $clog2(3 * INTERVAL_CAP);
    localparam int unsigned EW    = 2 * CW + 2 + 2 * IW;
    localparam int unsigned PW    = CW + 4;
    localparam int unsigned KW    = $clog2(LFSR_W);

    logic [EW-1:0]     r_mem [DEPTH];
    logic [EW-1:0]     r_rd;
    t_op               r_op;
    logic [AW-1:0]     r_idx;
    logic [OBS_W-1:0]  r_obs;
    t_res              r_res;
    t_res              r_out;
    logic              r_out_valid;
    logic [LFSR_W-1:0] r_lfsr;
    logic [LFSR_W-1:0] r_dvd;
    logic [IW-1:0]     r_dsr;
    logic [IW-1:0]     r_rem;
    logic [KW-1:0]     r_cnt;
    logic [IW-1:0]     r_base;
    logic              r_capped;
    logic [AW-1:0]     r_clr_addr;

    logic [CW-1:0]     e_oc;
    logic [CW-1:0]     e_rc;
    logic              e_vld;
    logic              e_typ;
    logic [IW-1:0]     e_ivl;
    logic [IW-1:0]     e_cnt;

    logic              in_range;
    logic [AW-1:0]     in_idx;
    logic [CW-1:0]     oc1;
    logic [CW-1:0]     rc1;
    logic [CW:0]       sum;
    logic              decay;
    logic [PW-1:0]     oc_x10;
    logic [PW-1:0]     rc_x10;
    logic              cls_vld;
    logic              cls_typ;
    logic              hit;
    logic [EW-1:0]     rec_entry;
    logic [EW-1:0]     lk_entry;
    logic [EW-1:0]     exec_entry;
    logic [IW-1:0]     iv_eff;
    logic              capped;
    logic [IW-1:0]     dsr;
    logic [LFSR_W-1:0] lfsr_step;
    logic [LFSR_W-1:0] seed;
    logic [IW:0]       rem_sh;
    logic [IW:0]       rem_sub;
    logic [IW:0]       fin_w;
    logic [IW-1:0]     fin_iv;
    logic [EW-1:0]     fin_entry;
    t_res              exec_res;

    assign {e_oc, e_rc, e_vld, e_typ, e_ivl, e_cnt} = r_rd;

    assign in_range = (i_size_class <= SIZE_W'(MAX_SIZE_CLASS));
    assign in_idx   = i_size_class[AW-1:0];

    // record: count update, ratio tests, decay
    always_comb begin
        oc1 = (r_obs == OBS_OPEN)     ? e_oc + CW'(1) : e_oc;
        rc1 = (r_obs == OBS_RESTRICT) ? e_rc + CW'(1) : e_rc;
        sum    = {1'b0, oc1} + {1'b0, rc1};
        decay  = (sum >= (CW + 1)'(DECAY_SUM));
        oc_x10 = PW'(oc1) * PW'(RATIO);
        rc_x10 = PW'(rc1) * PW'(RATIO);
        priority if (rc1 == '0) begin
            cls_vld = 1'b1;
            cls_typ = 1'b0;
        end else if (oc1 == '0) begin
            cls_vld = 1'b1;
            cls_typ = 1'b1;
        end else if (oc_x10 < PW'(rc1)) begin
            cls_vld = 1'b1;
            cls_typ = 1'b1;
        end else if (PW'(oc1) <= rc_x10) begin
            cls_vld = 1'b0;
            cls_typ = 1'b0;
        end else begin
            cls_vld = 1'b1;
            cls_typ = 1'b0;
        end
        rec_entry = {decay ? (oc1 >> 1) : oc1, decay ? (rc1 >> 1) : rc1,
                     cls_vld, cls_typ, e_ivl, e_cnt};
    end

    // lookup: hit counts down, invalid entry restarts at one
    always_comb begin
        hit = e_vld && (e_cnt != '0);
        if (hit) begin
            lk_entry = {e_oc, e_rc, e_vld, e_typ, e_ivl, e_cnt - IW'(1)};
        end else begin
            lk_entry = {e_oc, e_rc, e_vld, e_typ, IW'(1), IW'(1)};
        end
        exec_entry = (r_op == OP_RECORD) ? rec_entry : lk_entry;
        exec_res.quick_hit    = (r_op == OP_LOOKUP) && hit;
        exec_res.pred_type    = (r_op == OP_LOOKUP) && hit && e_typ;
        exec_res.out_of_range = 1'b0;
    end

    // backoff setup
    assign iv_eff    = (e_ivl == '0) ? IW'(1) : e_ivl;
    assign capped    = (iv_eff >= IW'(INTERVAL_CAP));
    assign dsr       = capped ? IW'(INTERVAL_CAP) : {iv_eff[IW-2:0], 1'b0};
    assign lfsr_step = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign seed      = (i_cfg_wdata == '0) ? LFSR_ONE : i_cfg_wdata;

    // one remainder bit per step
    assign rem_sh  = {r_rem, r_dvd[LFSR_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    assign fin_w = r_capped ? ((IW + 1)'(2 * INTERVAL_CAP) + {1'b0, r_rem})
                            : ({1'b0, r_base} + {1'b0, r_rem});
    assign fin_iv    = fin_w[IW-1:0];
    assign fin_entry = {e_oc, e_rc, e_vld, e_typ, fin_iv, fin_iv};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.exec_wr) begin
            r_mem[r_idx] <= exec_entry;
        end else if (i_cmd.fin_wr) begin
            r_mem[r_idx] <= fin_entry;
        end
        if (i_cmd.capture) begin
            r_rd <= r_mem[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_op);
            r_idx <= in_idx;
            r_obs <= i_observed_mapping;
        end
        if (i_cmd.capture) begin
            r_res <= '{quick_hit: 1'b0, pred_type: 1'b0, out_of_range: !in_range};
        end else if (i_cmd.exec_wr) begin
            r_res <= exec_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
        if (i_cmd.div_start) begin
            r_dvd    <= lfsr_step;
            r_dsr    <= dsr;
            r_rem    <= '0;
            r_base   <= iv_eff;
            r_capped <= capped;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[LFSR_W-2:0], 1'b0};
            r_rem <= rem_sub[IW] ? rem_sh[IW-1:0] : rem_sub[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr      <= LFSR_ONE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lfsr <= seed;
            end else if (i_cmd.div_start) begin
                r_lfsr <= lfsr_step;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + KW'(1);
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_comb begin
        o_stat.in_range   = in_range;
        o_stat.need_div   = (r_op == OP_LOOKUP) && e_vld && (e_cnt == '0);
        o_stat.div_last   = (r_cnt == KW'(LFSR_W - 1));
        o_stat.clear_last = (r_clr_addr == AW'(DEPTH - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_quick_hit    = r_out.quick_hit;
    assign o_pred_type    = r_out.pred_type;
    assign o_out_of_range = r_out.out_of_range;

endmodule

`default_nettype wire

@@ rtl/size_class_mapping_predictor.sv @@
// ----------------------------------------------------------------------------
// size_class_mapping_predictor
// Per size class open/restricted mapping predictor with randomized backoff.
// ----------------------------------------------------------------------------
// After reset the block sweeps its entry table to zero, one entry per cycle,
// over all MAX_SIZE_CLASS+1 entries (1024 by default), and takes no request
// word until that is done; seed writes are taken at any time. A request is
// then accepted, goes through the table read-modify-write, skipped for a size
// class out of range, and hands its result word to the output register, but
// not while that register still holds an unread word; only then is the next
// request accepted. A lookup miss on a valid entry whose countdown has run out
// also computes the new check interval in a serial remainder unit that retires
// one bit of the 32-bit lfsr value per cycle. The output register holds a
// finished result word while the next request is being worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_mapping_predictor import scmp_pkg::*; #(
    parameter int unsigned MAX_SIZE_CLASS = DEF_MAX_SIZE_CLASS,
    parameter int unsigned INTERVAL_CAP   = DEF_INTERVAL_CAP,
    parameter int unsigned DECAY_SUM      = DEF_DECAY_SUM
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LFSR_W-1:0] i_cfg_wdata,
    scmp_in_if.sink                i_in_ch,
    scmp_out_if.source             o_out_ch
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    scmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    scmp_dp #(
        .MAX_SIZE_CLASS (MAX_SIZE_CLASS),
        .INTERVAL_CAP   (INTERVAL_CAP),
        .DECAY_SUM      (DECAY_SUM)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_op               (i_in_ch.op),
        .i_size_class       (i_in_ch.size_class),
        .i_observed_mapping (i_in_ch.observed_mapping),
        .i_out_ready        (o_out_ch.ready),
        .o_out_valid        (o_out_ch.valid),
        .o_quick_hit        (o_out_ch.quick_hit),
        .o_pred_type        (o_out_ch.pred_type),
        .o_out_of_range     (o_out_ch.out_of_range)
    );

    assign i_in_ch.ready = w_cmd.in_ready;

    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready) |=> !i_in_ch.ready)
        else $error("request taken while previous word still in flight");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> w_cmd.div_step)
        else $error("backoff remainder did not start stepping");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_ch.valid) |-> $past(w_cmd.out_load))
        else $error("result word appeared without a load");

    a_no_ready_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear_wr |-> !i_in_ch.ready)
        else $error("request port open during table clear");

endmodule

`default_nettype wire
